>>> hdl/sbmq_pkg.sv
// Shared types and constants for the shared-buffer multi-queue.
// Used by sbmq_qtab, sbmq_estore, shared_buffer_multi_queue and its testbench; no dependencies.
package sbmq_pkg;

    // Default sizes handed down from the top level
    localparam int DEF_ENTRIES = 16;
    localparam int DEF_QUEUES  = 4;

    // Fixed field widths
    localparam int DATA_W = 32;
    localparam int QID_W  = 2;
    localparam int STAT_W = 2;

    // Operation codes
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // Data returned by a dequeue of an empty queue
    localparam logic signed [DATA_W-1:0] DATA_MINUS_ONE = '1;

    // Input word
    typedef struct packed {
        logic                     cmd;
        logic [QID_W-1:0]         queue_id;
        logic signed [DATA_W-1:0] data_in;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        logic [STAT_W-1:0]        status;
    } t_out_word;

    // Write strobes into the head/tail table
    typedef struct packed {
        logic head_we;
        logic tail_we;
    } t_qt_we;

    // Write strobes into the entry store
    typedef struct packed {
        logic link_we;
        logic value_we;
        logic alloc;
    } t_es_we;

endpackage

>>> hdl/sbmq_qtab.sv
// Per-queue head and tail pointer table, one address per cycle, shared by the read and the write.
// Depends on sbmq_pkg. Unwritten queues read as the null pointer through valid bits.
module sbmq_qtab #(
    parameter int QUEUES = 4,
    parameter int PW     = 5,
    parameter int QAW    = 2,
    parameter int ENTRIES = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [QAW-1:0]  i_addr,
    input  sbmq_pkg::t_qt_we i_we,
    input  logic [PW-1:0]   i_head_wd,
    input  logic [PW-1:0]   i_tail_wd,
    output logic [PW-1:0]   o_head_rd,
    output logic [PW-1:0]   o_tail_rd
);
    import sbmq_pkg::*;

    localparam logic [PW-1:0] NIL = PW'(ENTRIES);

    logic [PW-1:0] mem_head [QUEUES];
    logic [PW-1:0] mem_tail [QUEUES];
    logic [QUEUES-1:0] r_qv;
    logic [PW-1:0] r_head_rd;
    logic [PW-1:0] r_tail_rd;
    logic          r_rv;

    // Pointer memories
    always_ff @(posedge i_clk) begin
        if (i_we.head_we) begin
            mem_head[i_addr] <= i_head_wd;
        end
        if (i_we.tail_we) begin
            mem_tail[i_addr] <= i_tail_wd;
        end
        if (i_rd_en) begin
            r_head_rd <= mem_head[i_addr];
            r_tail_rd <= mem_tail[i_addr];
        end
    end

    // Valid bits: a queue never written reads as null; the first enqueue
    // of a queue writes head and tail together, so one bit covers both
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv <= '0;
            r_rv <= 1'b0;
        end else begin
            if (i_we.head_we || i_we.tail_we) begin
                r_qv[i_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rv <= r_qv[i_addr];
            end
        end
    end

    assign o_head_rd = r_rv ? r_head_rd : NIL;
    assign o_tail_rd = r_rv ? r_tail_rd : NIL;

endmodule

>>> hdl/sbmq_estore.sv
// Entry store: link pointers and stored values, with a fill count for the free chain.
// Depends on sbmq_pkg. Entries at or above the fill count read as linking to the next entry.
module sbmq_estore #(
    parameter int ENTRIES = 16,
    parameter int PW      = 5,
    parameter int EW      = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sbmq_pkg::t_es_we                  i_we,
    input  logic [PW-1:0]                     i_alloc_idx,
    input  logic [EW-1:0]                     i_link_wa,
    input  logic [PW-1:0]                     i_link_wd,
    input  logic [EW-1:0]                     i_value_wa,
    input  logic signed [sbmq_pkg::DATA_W-1:0] i_value_wd,
    input  logic                              i_rd_en,
    input  logic [EW-1:0]                     i_rd_addr,
    output logic [PW-1:0]                     o_link_rd,
    output logic signed [sbmq_pkg::DATA_W-1:0] o_value_rd
);
    import sbmq_pkg::*;

    logic [PW-1:0]            mem_link  [ENTRIES];
    logic signed [DATA_W-1:0] mem_value [ENTRIES];
    logic [PW-1:0]            r_fill;
    logic [PW-1:0]            r_link_rd;
    logic [PW-1:0]            r_next;
    logic                     r_fresh;
    logic signed [DATA_W-1:0] r_value_rd;

    // Memories, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we.link_we) begin
            mem_link[i_link_wa] <= i_link_wd;
        end
        if (i_we.value_we) begin
            mem_value[i_value_wa] <= i_value_wd;
        end
        if (i_rd_en) begin
            r_link_rd  <= mem_link[i_rd_addr];
            r_value_rd <= mem_value[i_rd_addr];
            r_next     <= PW'(i_rd_addr) + PW'(1);
        end
    end

    // Fill count: entries below it have had their link written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_fresh <= 1'b0;
        end else begin
            if (i_we.alloc && (i_alloc_idx == r_fill)) begin
                r_fill <= r_fill + PW'(1);
            end
            if (i_rd_en) begin
                r_fresh <= (PW'(i_rd_addr) >= r_fill);
            end
        end
    end

    // Untouched entries chain to the next one; the last gives the null code
    assign o_link_rd  = r_fresh ? r_next : r_link_rd;
    assign o_value_rd = r_value_rd;

endmodule

>>> hdl/shared_buffer_multi_queue.sv
// Channel   Valid        Stall        Word
// input     i_in_valid   o_in_stall   i_in_word  (cmd, queue_id, data_in)
// output    o_out_valid  i_out_stall  o_out_word (data_out, status)
//
// An enqueue or a dequeue passes S_READ and two further states before its result is registered, a rejected
// one S_READ and one more; a new word is taken only back in S_IDLE, once the last item is through.
// The one-read, one-write ports of the pointer table and entry store set the step count.
// The input stalls from acceptance until the result is in the output register.
// A stalled output holds the sequencer in its final step, with no state written.
// Reset is synchronous and immediate; no clearing pass is needed.
// Depends on sbmq_pkg, sbmq_qtab and sbmq_estore.
module shared_buffer_multi_queue #(
    parameter int ENTRIES = sbmq_pkg::DEF_ENTRIES,
    parameter int QUEUES  = sbmq_pkg::DEF_QUEUES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sbmq_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sbmq_pkg::t_out_word o_out_word
);
    import sbmq_pkg::*;

    localparam int PW  = $clog2(ENTRIES + 1);
    localparam int EW  = $clog2(ENTRIES);
    localparam int QAW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam logic [PW-1:0] NIL = PW'(ENTRIES);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_READ     = 6'b000010,
        S_ENQ_LINK = 6'b000100,
        S_ENQ_DONE = 6'b001000,
        S_DEQ_HEAD = 6'b010000,
        S_DEQ_DONE = 6'b100000
    } t_state;

    t_state    r_state, n_state;
    t_in_word  r_item, n_item;
    logic [PW-1:0] r_idx, n_idx;
    logic [PW-1:0] r_free_head, n_free_head;
    logic      r_out_valid;
    t_out_word r_out;

    logic [QAW-1:0] w_q;
    logic           w_q_ok;
    logic           w_head_ok;
    logic           w_tail_ok;
    logic           w_out_free;
    logic           w_emit;
    t_out_word      w_emit_word;

    t_qt_we         w_qt_we;
    logic           w_qt_rd_en;
    logic [PW-1:0]  w_qt_head_wd;
    logic [PW-1:0]  w_qt_tail_wd;
    logic [PW-1:0]  w_head_rd;
    logic [PW-1:0]  w_tail_rd;

    t_es_we         w_es_we;
    logic [EW-1:0]  w_link_wa;
    logic [PW-1:0]  w_link_wd;
    logic [EW-1:0]  w_value_wa;
    logic           w_es_rd_en;
    logic [EW-1:0]  w_es_rd_addr;
    logic [PW-1:0]  w_link_rd;
    logic signed [DATA_W-1:0] w_value_rd;

    // Head/tail table
    sbmq_qtab #(
        .QUEUES  (QUEUES),
        .PW      (PW),
        .QAW     (QAW),
        .ENTRIES (ENTRIES)
    ) u_qtab (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_qt_rd_en),
        .i_addr    (w_q),
        .i_we      (w_qt_we),
        .i_head_wd (w_qt_head_wd),
        .i_tail_wd (w_qt_tail_wd),
        .o_head_rd (w_head_rd),
        .o_tail_rd (w_tail_rd)
    );

    // Entry store
    sbmq_estore #(
        .ENTRIES (ENTRIES),
        .PW      (PW),
        .EW      (EW)
    ) u_estore (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_we        (w_es_we),
        .i_alloc_idx (r_free_head),
        .i_link_wa   (w_link_wa),
        .i_link_wd   (w_link_wd),
        .i_value_wa  (w_value_wa),
        .i_value_wd  (r_item.data_in),
        .i_rd_en     (w_es_rd_en),
        .i_rd_addr   (w_es_rd_addr),
        .o_link_rd   (w_link_rd),
        .o_value_rd  (w_value_rd)
    );

    // Pointer checks
    assign w_q        = QAW'(r_item.queue_id);
    assign w_q_ok     = 32'(r_item.queue_id) < QUEUES;
    assign w_head_ok  = w_head_rd < NIL;
    assign w_tail_ok  = w_tail_rd < NIL;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_idx        = r_idx;
        n_free_head  = r_free_head;
        w_qt_we      = '0;
        w_qt_rd_en   = 1'b0;
        w_qt_head_wd = r_free_head;
        w_qt_tail_wd = r_free_head;
        w_es_we      = '0;
        w_link_wa    = w_tail_rd[EW-1:0];
        w_link_wd    = r_free_head;
        w_value_wa   = r_free_head[EW-1:0];
        w_es_rd_en   = 1'b0;
        w_es_rd_addr = r_free_head[EW-1:0];
        w_emit       = 1'b0;
        w_emit_word  = '{data_out: '0, status: ST_OK};

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_word;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // fetch queue pointers and the link of the free head
                w_qt_rd_en = 1'b1;
                w_es_rd_en = 1'b1;
                n_state    = (r_item.cmd == CMD_ENQ) ? S_ENQ_LINK : S_DEQ_HEAD;
            end
            S_ENQ_LINK: begin
                if (!w_q_ok || !(r_free_head < NIL)) begin
                    w_emit_word = '{data_out: '0, status: ST_FULL};
                    if (w_out_free) begin
                        w_emit  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    // pop the free entry, hang it after the tail
                    n_idx            = r_free_head;
                    n_free_head      = w_link_rd;
                    w_es_we.alloc    = 1'b1;
                    w_es_we.value_we = 1'b1;
                    w_qt_we.tail_we  = 1'b1;
                    if (!w_head_ok) begin
                        w_qt_we.head_we = 1'b1;
                    end else if (w_tail_ok) begin
                        w_es_we.link_we = 1'b1;
                    end
                    n_state = S_ENQ_DONE;
                end
            end
            S_ENQ_DONE: begin
                // terminate the new entry's link
                w_link_wa   = r_idx[EW-1:0];
                w_link_wd   = NIL;
                w_emit_word = '{data_out: '0, status: ST_OK};
                if (w_out_free) begin
                    w_es_we.link_we = 1'b1;
                    w_emit          = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_DEQ_HEAD: begin
                if (!w_q_ok || !w_head_ok) begin
                    w_emit_word = '{data_out: DATA_MINUS_ONE, status: ST_EMPTY};
                    if (w_out_free) begin
                        w_emit  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_idx        = w_head_rd;
                    w_es_rd_en   = 1'b1;
                    w_es_rd_addr = w_head_rd[EW-1:0];
                    n_state      = S_DEQ_DONE;
                end
            end
            S_DEQ_DONE: begin
                // unlink the head, push it on the free list
                w_qt_head_wd = w_link_rd;
                w_link_wa    = r_idx[EW-1:0];
                w_link_wd    = r_free_head;
                w_emit_word  = '{data_out: w_value_rd, status: ST_OK};
                if (w_out_free) begin
                    w_qt_we.head_we = 1'b1;
                    w_es_we.link_we = 1'b1;
                    n_free_head     = r_idx;
                    w_emit          = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_idx  <= n_idx;
        if (w_emit) begin
            r_out <= w_emit_word;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a word is in progress");

    a_free_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_head <= NIL)
        else $error("free head beyond the null code");

    a_emit_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_state == S_IDLE))
        else $error("result written without returning to idle");

    a_full_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status == ST_FULL)) |-> (o_out_word.data_out == '0))
        else $error("store-full result carries non-zero data");
`endif

endmodule

>>> tb/shared_buffer_multi_queue_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for shared_buffer_multi_queue: random and directed queue traffic,
// checked against a cycle-free predictor of the linked-list store. Depends on sbmq_pkg.
module shared_buffer_multi_queue_tb;
    import sbmq_pkg::*;

    localparam int N_ENTRIES = 16;
    localparam int N_QUEUES  = 4;
    localparam int PTR_W     = 5;
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(N_ENTRIES);
    localparam int RAND_ITEMS = 950;
    localparam int IDLE_PCT   = 19;

    typedef struct {
        t_in_word word;
        bit       drain_first;
    } t_stim_item;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    // Predictor state: mirror of the pointer table and entry store
    logic [PTR_W-1:0]  q_head [N_QUEUES];
    logic [PTR_W-1:0]  q_tail [N_QUEUES];
    logic [PTR_W-1:0]  next_entry [N_ENTRIES];
    logic [DATA_W-1:0] entry_data [N_ENTRIES];
    logic [PTR_W-1:0]  free_top;

    t_stim_item stim_items[$];
    t_out_word  expected_words[$];
    int total_items;
    int launched_count = 0;
    int accepted_count = 0;
    int results_count = 0;
    int error_count = 0;
    logic calm;

    shared_buffer_multi_queue #(
        .ENTRIES(N_ENTRIES),
        .QUEUES (N_QUEUES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    always #5 i_clk = ~i_clk;

    // No idling on either side through a long middle stretch
    assign calm = (accepted_count >= 450) && (accepted_count < 650);

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t: mismatch on result %0d, %s: got %h, want %h",
                 $realtime, results_count, what, got, want);
        error_count++;
    endtask

    function automatic bit holds_entry(input logic [PTR_W-1:0] ptr);
        return ptr < N_ENTRIES;
    endfunction

    function automatic void clear_store();
        for (int q = 0; q < N_QUEUES; q++) begin
            q_head[q] = NULL_PTR;
            q_tail[q] = NULL_PTR;
        end
        for (int e = 0; e < N_ENTRIES; e++) begin
            next_entry[e] = PTR_W'(e + 1);
            entry_data[e] = '0;
        end
        next_entry[N_ENTRIES-1] = NULL_PTR;
        free_top = '0;
    endfunction

    // Apply one queue operation to the predictor and return its answer
    function automatic t_out_word apply_queue_op(input t_in_word w);
        t_out_word        res;
        logic [PTR_W-1:0] idx;
        int               q;
        q = int'(w.queue_id);
        if (w.cmd == CMD_ENQ) begin
            res.data_out = '0;
            if (q >= N_QUEUES || !holds_entry(free_top)) begin
                res.status = ST_FULL;
                return res;
            end
            idx = free_top;
            free_top = next_entry[idx];
            if (!holds_entry(q_head[q]))
                q_head[q] = idx;
            else if (holds_entry(q_tail[q]))
                next_entry[q_tail[q]] = idx;
            next_entry[idx] = NULL_PTR;
            q_tail[q] = idx;
            entry_data[idx] = w.data_in;
            res.status = ST_OK;
            return res;
        end
        if (q >= N_QUEUES || !holds_entry(q_head[q])) begin
            res.data_out = DATA_MINUS_ONE;
            res.status = ST_EMPTY;
            return res;
        end
        idx = q_head[q];
        q_head[q] = next_entry[idx];
        next_entry[idx] = free_top;
        free_top = idx;
        res.data_out = entry_data[idx];
        res.status = ST_OK;
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] edge_value(input int k);
        case (k % 6)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h5555_5555;
            default: return 32'hAAAA_AAAA;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(7) == 0)
            return edge_value($urandom_range(5));
        return $urandom;
    endfunction

    task automatic add_item(input logic cmd, input int qid, input logic [DATA_W-1:0] val,
                            input bit drain);
        t_stim_item it;
        it.word.cmd = cmd;
        it.word.queue_id = QID_W'(qid);
        it.word.data_in = val;
        it.drain_first = drain;
        stim_items.push_back(it);
    endtask

    // Input driver: one word in flight, random idle gaps, optional drain hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && launched_count > accepted_count)) begin
            if (stim_items.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (stim_items[0].drain_first && results_count != accepted_count) begin
                i_in_valid <= 1'b0;
            end else if (!calm && $urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
            end else begin
                i_in_word <= stim_items[0].word;
                i_in_valid <= 1'b1;
                void'(stim_items.pop_front());
                launched_count <= launched_count + 1;
            end
        end
    end

    // Output back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n && !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // Monitor: check results first, then record the newly accepted word
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", o_out_word.data_out, '0);
                end else begin
                    want = expected_words.pop_front();
                    if (o_out_word.data_out !== want.data_out)
                        report_mismatch("data_out", o_out_word.data_out, want.data_out);
                    if (o_out_word.status !== want.status)
                        report_mismatch("status", DATA_W'(o_out_word.status),
                                        DATA_W'(want.status));
                end
                results_count <= results_count + 1;
            end
            if (i_in_valid && !o_in_stall) begin
                expected_words.push_back(apply_queue_op(i_in_word));
                accepted_count <= accepted_count + 1;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int p_enq;
        int hot_q;
        int qid;

        clear_store();

        // Directed: empty dequeues, fill the store (mostly edge values), overflow, then one dequeue per queue
        for (int q = 0; q < N_QUEUES; q++)
            add_item(CMD_DEQ, q, $urandom, 1'b0);
        for (int k = 0; k < N_ENTRIES; k++)
            add_item(CMD_ENQ, k % N_QUEUES, (k < 12) ? edge_value(k) : $urandom, 1'b0);
        add_item(CMD_ENQ, 2, 32'h1234_5678, 1'b1);
        for (int q = 0; q < N_QUEUES; q++)
            add_item(CMD_DEQ, q, '1, 1'b0);

        // Random: phases lean towards filling, draining or balance
        hot_q = 0;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i % 100 == 0)
                hot_q = $urandom_range(N_QUEUES - 1);
            case ((i / 100) % 3)
                0: p_enq = 75;
                1: p_enq = 30;
                default: p_enq = 50;
            endcase
            qid = ($urandom_range(2) == 0) ? hot_q : $urandom_range(N_QUEUES - 1);
            add_item(($urandom_range(99) < p_enq) ? CMD_ENQ : CMD_DEQ, qid, pick_value(),
                     (i == 300) || (i == 720));
        end
        total_items = stim_items.size();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (accepted_count < total_items || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
